// ----- rtl/stepper_phase_sequencer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// stepper phase sequencer assertion macros
// property forms for the sequencer checker
// ----------------------------------------------------------------------------
`ifndef STEPPER_PHASE_SEQUENCER_UNIT_ASSERT_SVH
`define STEPPER_PHASE_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SPS_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define SPS_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// types, codes and coil tables of the stepper phase sequencer
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned PosBits   = 32;
  localparam int unsigned PosOutW   = 32;
  localparam int unsigned OpW       = 3;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned PhaseW    = 3;
  localparam int unsigned CountW    = 16;
  localparam int unsigned CoilW     = 4;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [OpW-1:0] {
    OP_TICK    = 3'd0,
    OP_STEP    = 3'd1,
    OP_START   = 3'd2,
    OP_HOLD    = 3'd3,
    OP_RELEASE = 3'd4,
    OP_CLEAR   = 3'd5
  } op_e;

  typedef enum logic [ModeW-1:0] {
    MODE_WAVE = 2'd0,
    MODE_FULL = 2'd1,
    MODE_HALF = 2'd2
  } mode_e;

  // spare mode code, a write of it is dropped
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_STEP_MODE  = 2'd0,
    CFG_STEP_DELAY = 2'd1,
    CFG_USE_ENABLE = 2'd2
  } cfg_index_e;

  localparam logic [CoilW-1:0] WAVE_TAB [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [CoilW-1:0] FULL_TAB [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [CoilW-1:0] HALF_TAB [8] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  function automatic logic [CoilW-1:0] coil_entry(mode_e mode, logic [PhaseW-1:0] idx);
    logic [CoilW-1:0] pat;
    unique case (mode)
      MODE_WAVE: pat = WAVE_TAB[idx[1:0]];
      MODE_HALF: pat = HALF_TAB[idx];
      default:   pat = FULL_TAB[idx[1:0]];
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/stepper_phase_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// stepper phase sequencer unit
// coil pattern, position and timed move control for one stepper bridge
// result: registered, on the output in the cycle after the item is accepted
// throughput: one item per cycle while results are taken; the result register
//   frees in the cycle it is taken, so the next item enters in that same cycle
// reset: no result pending, phase, position, coils and move cleared,
//   step_mode full step, step_delay one, use_enable off
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sps_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [sps_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sps_pkg::OpW-1:0]            operation_i,
  input  logic                               direction_i,
  input  logic [sps_pkg::CountW-1:0]         step_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sps_pkg::CoilW-1:0]          coils_o,
  output logic                               energized_o,
  output logic                               bridge_enable_o,
  output logic signed [sps_pkg::PosOutW-1:0] position_o,
  output logic                               moving_o,
  output logic [sps_pkg::CountW-1:0]         steps_left_o,
  output logic                               stepped_o,
  output logic                               status_o
);
  import sps_pkg::*;

  mode_e               mode_q, mode_d;
  logic [CountW-1:0]   delay_q, delay_d;
  logic                use_en_q, use_en_d;
  logic [PhaseW-1:0]   phase_q, phase_d;
  logic [PosBits-1:0]  pos_q, pos_d;
  logic [CoilW-1:0]    coil_q, coil_d;
  logic                en_q, en_d;
  logic                active_q, active_d;
  logic                mdir_q, mdir_d;
  logic [CountW-1:0]   remain_q, remain_d;
  logic [CountW-1:0]   tick_q, tick_d;
  logic                out_valid_q;
  logic                stepped_q, stepped_d;
  logic                status_q, status_d;

  logic                accept;
  logic                do_step;
  logic                step_dir;
  logic [PhaseW-1:0]   phase_up;
  logic [PhaseW-1:0]   phase_dn;
  logic [PhaseW-1:0]   phase_stp;
  logic [CountW-1:0]   remain_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // a tick steps in the move direction, a single step in the item direction
  assign step_dir = (operation_i == OP_TICK) ? mdir_q : direction_i;

  // phase neighbors: eight entries in half step, four otherwise
  always_comb begin
    phase_up = phase_q + PhaseW'(1);
    phase_dn = phase_q - PhaseW'(1);
    if (mode_q != MODE_HALF) begin
      phase_up[PhaseW-1] = 1'b0;
      phase_dn[PhaseW-1] = 1'b0;
    end
    phase_stp = step_dir ? phase_dn : phase_up;
  end

  assign remain_dec = remain_q - CountW'(1);

  always_comb begin
    mode_d    = mode_q;
    delay_d   = delay_q;
    use_en_d  = use_en_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    coil_d    = coil_q;
    en_d      = en_q;
    active_d  = active_q;
    mdir_d    = mdir_q;
    remain_d  = remain_q;
    tick_d    = tick_q;
    stepped_d = 1'b0;
    status_d  = 1'b0;
    do_step   = 1'b0;

    if (accept) begin
      unique case (op_e'(operation_i))
        OP_TICK: begin
          if (active_q) begin
            if (tick_q <= CountW'(1)) begin
              do_step  = 1'b1;
              remain_d = remain_dec;
              tick_d   = delay_q;
              if (remain_dec == '0) begin
                active_d = 1'b0;
              end
            end else begin
              tick_d = tick_q - CountW'(1);
            end
          end
        end
        OP_STEP: begin
          do_step = 1'b1;
        end
        OP_START: begin
          if (step_count_i == '0 || active_q) begin
            status_d = 1'b1;
          end else begin
            active_d = 1'b1;
            remain_d = step_count_i;
            mdir_d   = direction_i;
            tick_d   = delay_q;
          end
        end
        OP_HOLD: begin
          if (use_en_q) begin
            en_d = 1'b1;
          end
          coil_d = coil_entry(mode_q, phase_q);
        end
        OP_RELEASE: begin
          coil_d = '0;
          if (use_en_q) begin
            en_d = 1'b0;
          end
        end
        OP_CLEAR: begin
          pos_d = '0;
        end
        default: begin
          status_d = 1'b1;
        end
      endcase

      if (do_step) begin
        stepped_d = 1'b1;
        phase_d   = phase_stp;
        coil_d    = coil_entry(mode_q, phase_stp);
        pos_d     = step_dir ? pos_q - PosBits'(1) : pos_q + PosBits'(1);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_STEP_MODE: begin
          // the unused mode code leaves mode and phase alone
          if (cfg_wdata_i[ModeW-1:0] != MODE_UNUSED) begin
            mode_d  = mode_e'(cfg_wdata_i[ModeW-1:0]);
            phase_d = '0;
          end
        end
        CFG_STEP_DELAY: begin
          delay_d = (cfg_wdata_i == '0) ? CountW'(1) : cfg_wdata_i;
        end
        CFG_USE_ENABLE: begin
          use_en_d = cfg_wdata_i[0];
          en_d     = cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_FULL;
      delay_q     <= CountW'(1);
      use_en_q    <= 1'b0;
      phase_q     <= '0;
      pos_q       <= '0;
      coil_q      <= '0;
      en_q        <= 1'b0;
      active_q    <= 1'b0;
      mdir_q      <= 1'b0;
      remain_q    <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      stepped_q   <= 1'b0;
      status_q    <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      delay_q  <= delay_d;
      use_en_q <= use_en_d;
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      coil_q   <= coil_d;
      en_q     <= en_d;
      active_q <= active_d;
      mdir_q   <= mdir_d;
      remain_q <= remain_d;
      tick_q   <= tick_d;
      if (accept) begin
        out_valid_q <= 1'b1;
        stepped_q   <= stepped_d;
        status_q    <= status_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // only accepted items and register writes change state while a result waits
  assign out_valid_o     = out_valid_q;
  assign coils_o         = coil_q;
  assign energized_o     = |coil_q;
  assign bridge_enable_o = en_q;
  assign position_o      = PosOutW'($signed(pos_q));
  assign moving_o        = active_q;
  assign steps_left_o    = remain_q;
  assign stepped_o       = stepped_q;
  assign status_o        = status_q;

endmodule

// ----- rtl/sps_checker.sv -----
// ----------------------------------------------------------------------------
// sps checker
// port-level properties of the stepper phase sequencer unit
// ----------------------------------------------------------------------------
`include "stepper_phase_sequencer_unit_assert.svh"

module sps_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [sps_pkg::OpW-1:0]            operation_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [sps_pkg::CoilW-1:0]          coils_o,
  input logic                               energized_o,
  input logic                               moving_o,
  input logic                               stepped_o,
  input logic                               status_o
);
  import sps_pkg::*;

  `SPS_ASSERT_IMP(a_energized_match, clk_i, rst_ni, 1'b1, energized_o == (|coils_o), "energized disagrees with coils")
  `SPS_ASSERT_IMP(a_stall_blocks_input, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input ready while result stalled")
  `SPS_ASSERT_NXT(a_bad_op_rejected, clk_i, rst_ni, in_valid_i && in_ready_o && operation_i > OP_CLEAR, out_valid_o && status_o, "unused operation not rejected")
  `SPS_ASSERT_IMP(a_move_ends_on_step, clk_i, rst_ni, $fell(moving_o), out_valid_o && stepped_o, "move ended without a step")
  `SPS_ASSERT_NXT(a_result_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped before taken")

endmodule

bind stepper_phase_sequencer_unit sps_checker u_sps_checker (.*);

// ----- dv/stepper_phase_sequencer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper phase sequencer unit testbench
// drives command items through the valid/ready port, predicts coil, enable,
// position and timed move results in lockstep, and checks every result field
// across wave, full and half step settings with random idling on both sides
// ----------------------------------------------------------------------------
module stepper_phase_sequencer_unit_tb;
  import sps_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned MAX_TICKS   = 40;

  localparam logic [OpW-1:0]   OP_SPARE_LO = 3'd6;
  localparam logic [OpW-1:0]   OP_SPARE_HI = 3'd7;
  localparam logic             DIR_CW      = 1'b0;
  localparam logic             DIR_CCW     = 1'b1;

  localparam logic [CoilW-1:0] ONE_COIL_SEQ [4] = '{4'h1, 4'h2, 4'h4, 4'h8};
  localparam logic [CoilW-1:0] TWO_COIL_SEQ [4] = '{4'h3, 4'h6, 4'hC, 4'h9};
  localparam logic [CoilW-1:0] MIXED_SEQ    [8] =
    '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic              dir;
    logic [CountW-1:0] count;
  } motor_cmd_t;

  typedef struct packed {
    logic [CoilW-1:0]          coils;
    logic                      energized;
    logic                      bridge_en;
    logic signed [PosOutW-1:0] position;
    logic                      moving;
    logic [CountW-1:0]         steps_left;
    logic                      stepped;
    logic                      status;
  } motor_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CfgIndexW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_wdata_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [OpW-1:0]        operation_i = '0;
  logic                  direction_i = 1'b0;
  logic [CountW-1:0]     step_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [CoilW-1:0]      coils_o;
  logic                  energized_o;
  logic                  bridge_enable_o;
  logic signed [PosOutW-1:0] position_o;
  logic                  moving_o;
  logic [CountW-1:0]     steps_left_o;
  logic                  stepped_o;
  logic                  status_o;

  stepper_phase_sequencer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .direction_i    (direction_i),
    .step_count_i   (step_count_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coils_o        (coils_o),
    .energized_o    (energized_o),
    .bridge_enable_o(bridge_enable_o),
    .position_o     (position_o),
    .moving_o       (moving_o),
    .steps_left_o   (steps_left_o),
    .stepped_o      (stepped_o),
    .status_o       (status_o)
  );

  motor_cmd_t    pending_cmds[$];
  motor_result_t predicted_outputs[$];
  motor_cmd_t    nxt_cmd;
  motor_result_t seen_result;
  motor_result_t want_result;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   queued_count = 0;
  int unsigned   quiet_cycles = 0;
  bit            failed = 1'b0;

  // shadow of the sequencer registers and state
  logic [ModeW-1:0]   cur_mode = MODE_FULL;
  logic [CountW-1:0]  cur_delay = 16'd1;
  logic               cur_use_en = 1'b0;
  logic [PhaseW-1:0]  phase_idx = '0;
  logic [PosBits-1:0] step_pos = '0;
  logic [CoilW-1:0]   coil_pat = '0;
  logic               coils_live = 1'b0;
  logic               enable_lvl = 1'b0;
  logic               move_on = 1'b0;
  logic               move_dir = 1'b0;
  logic [CountW-1:0]  move_left = '0;
  logic [CountW-1:0]  tick_wait = '0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CoilW-1:0] pattern_at(logic [PhaseW-1:0] idx);
    case (cur_mode)
      MODE_WAVE: return ONE_COIL_SEQ[idx[1:0]];
      MODE_HALF: return MIXED_SEQ[idx];
      default:   return TWO_COIL_SEQ[idx[1:0]];
    endcase
  endfunction

  function automatic void drive_coils(logic [CoilW-1:0] pat);
    coil_pat   = pat;
    coils_live = (pat != '0);
  endfunction

  function automatic void advance_phase(logic d);
    logic [3:0] len;
    logic [3:0] p;
    len = (cur_mode == MODE_HALF) ? 4'd8 : 4'd4;
    p   = {1'b0, phase_idx} % len;
    if (d == DIR_CW) begin
      phase_idx = PhaseW'((p + 4'd1) % len);
      step_pos  = step_pos + 1'b1;
    end else begin
      phase_idx = PhaseW'((p + len - 4'd1) % len);
      step_pos  = step_pos - 1'b1;
    end
    drive_coils(pattern_at(phase_idx));
  endfunction

  function automatic motor_result_t predict_motor(motor_cmd_t c);
    motor_result_t r;
    r = '0;
    case (c.op)
      OP_TICK: begin
        if (move_on) begin
          if (tick_wait <= 16'd1) begin
            advance_phase(move_dir);
            r.stepped = 1'b1;
            move_left = move_left - 1'b1;
            tick_wait = cur_delay;
            if (move_left == '0) move_on = 1'b0;
          end else begin
            tick_wait = tick_wait - 1'b1;
          end
        end
      end
      OP_STEP: begin
        advance_phase(c.dir);
        r.stepped = 1'b1;
      end
      OP_START: begin
        if (c.count == '0 || move_on) begin
          r.status = 1'b1;
        end else begin
          move_on   = 1'b1;
          move_left = c.count;
          move_dir  = c.dir;
          tick_wait = cur_delay;
        end
      end
      OP_HOLD: begin
        if (cur_use_en) enable_lvl = 1'b1;
        drive_coils(pattern_at(phase_idx));
      end
      OP_RELEASE: begin
        drive_coils('0);
        if (cur_use_en) enable_lvl = 1'b0;
      end
      OP_CLEAR: step_pos = '0;
      default: r.status = 1'b1;
    endcase
    r.coils      = coil_pat;
    r.energized  = coils_live;
    r.bridge_en  = enable_lvl;
    r.position   = $signed(step_pos);
    r.moving     = move_on;
    r.steps_left = move_left;
    return r;
  endfunction

  // register writes and accepted items update the shadow state
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_index_i)
        CFG_STEP_MODE: begin
          if (cfg_wdata_i[ModeW-1:0] != MODE_UNUSED) begin
            cur_mode  = cfg_wdata_i[ModeW-1:0];
            phase_idx = '0;
          end
        end
        CFG_STEP_DELAY: cur_delay = (cfg_wdata_i == '0) ? 16'd1 : cfg_wdata_i;
        CFG_USE_ENABLE: begin
          cur_use_en = cfg_wdata_i[0];
          enable_lvl = cfg_wdata_i[0];
        end
        default: ;
      endcase
    end
    if (rst_ni && in_valid_i && in_ready_o)
      predicted_outputs.push_back(predict_motor('{operation_i, direction_i, step_count_i}));
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt_cmd = pending_cmds.pop_front();
        operation_i  <= nxt_cmd.op;
        direction_i  <= nxt_cmd.dir;
        step_count_i <= nxt_cmd.count;
        in_valid_i   <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, fname, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_result = '{coils_o, energized_o, bridge_enable_o, position_o, moving_o,
                      steps_left_o, stepped_o, status_o};
      if (predicted_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, seen_result);
        failed = 1'b1;
      end else begin
        want_result = predicted_outputs.pop_front();
        check_field("coils", want_result.coils, seen_result.coils);
        check_field("energized", want_result.energized, seen_result.energized);
        check_field("bridge_enable", want_result.bridge_en, seen_result.bridge_en);
        check_field("position", want_result.position, seen_result.position);
        check_field("moving", want_result.moving, seen_result.moving);
        check_field("steps_left", want_result.steps_left, seen_result.steps_left);
        check_field("stepped", want_result.stepped, seen_result.stepped);
        check_field("status", want_result.status, seen_result.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void push_cmd(logic [OpW-1:0] op, logic dir, logic [CountW-1:0] cnt);
    pending_cmds.push_back('{op, dir, cnt});
    queued_count++;
  endfunction

  function automatic void push_noise();
    logic [OpW-1:0] op;
    logic [CountW-1:0] cnt;
    op = OpW'($urandom_range(7));
    if (op == OP_START) cnt = ($urandom_range(3) == 0) ? '0 : CountW'($urandom_range(1, 4));
    else cnt = CountW'($urandom_range(65535));
    push_cmd(op, 1'($urandom_range(1)), cnt);
  endfunction

  // start a short move, maybe probe it by a second start, tick up to MAX_TICKS
  function automatic void push_move_burst();
    int unsigned n;
    int unsigned ticks;
    n = $urandom_range(1, 6);
    ticks = n * cur_delay + $urandom_range(0, 2);
    if (ticks > MAX_TICKS) ticks = MAX_TICKS;
    push_cmd(OP_START, 1'($urandom_range(1)), CountW'(n));
    if ($urandom_range(3) == 0)
      push_cmd(OP_START, 1'($urandom_range(1)), CountW'($urandom_range(65535)));
    for (int unsigned k = 0; k < ticks; k++) begin
      if ($urandom_range(99) < 15) push_noise();
      push_cmd(OP_TICK, 1'($urandom_range(1)), CountW'($urandom_range(65535)));
    end
  endfunction

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid_i || predicted_outputs.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_index_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_phase(logic [ModeW-1:0] mode, logic [CountW-1:0] delay, logic use_en,
                           int unsigned idle_pct, int unsigned stall_pct);
    drain();
    write_reg(CFG_STEP_MODE, {{(CfgDataW-ModeW){1'b0}}, mode});
    write_reg(CFG_STEP_DELAY, delay);
    write_reg(CFG_USE_ENABLE, {{(CfgDataW-1){1'b0}}, use_en});
    @(posedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queued_count   = 0;
    while (queued_count < PHASE_ITEMS) begin
      if ($urandom_range(99) < 70) push_move_burst();
      else push_noise();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full step, delay one, enables not driven
    push_cmd(OP_TICK, DIR_CW, '0);
    push_cmd(OP_HOLD, DIR_CW, '0);
    push_cmd(OP_STEP, DIR_CW, 16'hFFFF);
    push_cmd(OP_STEP, DIR_CCW, '0);
    push_cmd(OP_STEP, DIR_CCW, '0);       // position goes negative
    push_cmd(OP_RELEASE, DIR_CW, '0);
    push_cmd(OP_CLEAR, DIR_CCW, 16'hFFFF);
    push_cmd(OP_START, DIR_CW, '0);       // zero-step move is rejected
    push_cmd(OP_START, DIR_CCW, 16'd3);
    push_cmd(OP_START, DIR_CW, 16'hFFFF); // busy
    push_cmd(OP_START, DIR_CCW, CountW'($urandom_range(65535)));
    push_cmd(OP_STEP, DIR_CW, '0);        // single step while moving
    push_cmd(OP_CLEAR, DIR_CW, '0);       // clear while moving
    push_cmd(OP_TICK, DIR_CW, '0);
    push_cmd(OP_TICK, DIR_CW, '0);
    push_cmd(OP_TICK, DIR_CW, '0);
    push_cmd(OP_TICK, DIR_CW, '0);
    push_cmd(OP_SPARE_LO, DIR_CCW, 16'hFFFF);
    push_cmd(OP_SPARE_HI, DIR_CW, 16'h5A5A);
    push_cmd(OP_START, DIR_CW, 16'd1);
    push_cmd(OP_TICK, DIR_CCW, '0);
    push_cmd(OP_HOLD, DIR_CW, '0);
    push_cmd(OP_RELEASE, DIR_CW, '0);

    run_phase(MODE_WAVE, 16'd1, 1'b1, 0, 0);
    run_phase(MODE_HALF, 16'd3, 1'b0, 59, 0);
    run_phase(MODE_FULL, 16'd2, 1'b1, 0, 59);
    run_phase(MODE_HALF, 16'd0, 1'b1, 37, 37);
    // unused mode code keeps half step and the current phase
    run_phase(MODE_UNUSED, 16'd5, 1'b0, 0, 0);
    // moves here never finish, so this setting stays last
    run_phase(MODE_WAVE, 16'hFFFF, 1'b1, 37, 37);

    drain();
    repeat (5) @(posedge clk_i);
    if (!failed && predicted_outputs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
